// File: rtl/core/assert_macros.svh
// Assertion helpers used by ray_box_slab_test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RBS_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define RBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/rbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants
// Fixed-point format and divider geometry for the ray/box slab test.
// ----------------------------------------------------------------------------
package rbs_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_AXES    = 3;

   // magnitude of corner - origin, and the shifted dividend
   localparam int NUM_W  = COORD_WIDTH + 1;
   localparam int DIVD_W = NUM_W + FRAC_BITS;
   localparam int REM_W  = COORD_WIDTH + 1;

   // lane depth: prep register, one stage per quotient bit, saturate register
   localparam int LANE_LAT = DIVD_W + 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type COORD_MAX = coord_type'((64'd1 << (COORD_WIDTH-1)) - 64'd1);
   localparam coord_type COORD_MIN = coord_type'(64'd1 << (COORD_WIDTH-1));

   localparam logic [DIVD_W-1:0] Q_POS_LIM = DIVD_W'((64'd1 << (COORD_WIDTH-1)) - 64'd1);
   localparam logic [DIVD_W-1:0] Q_NEG_LIM = DIVD_W'(64'd1 << (COORD_WIDTH-1));
endpackage
`default_nettype wire

// File: rtl/core/ray_box_slab_test.sv
// Each accepted word runs through a 51-stage lane, the merge and an output reg to the result word.
// Throughput: one word per cycle while no result word is stalled; six divide lanes, one quotient bit per stage.
// The whole pipeline holds while a result word is stalled.
// Reset clears the valid bits only; payload stages are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ray_box_slab_test: ray vs. axis-aligned box slab test
// Six pipelined plane-distance lanes feed an interval merge.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rbs_pkg::coord_type req_box_min_x,
   input  wire rbs_pkg::coord_type req_box_min_y,
   input  wire rbs_pkg::coord_type req_box_min_z,
   input  wire rbs_pkg::coord_type req_box_max_x,
   input  wire rbs_pkg::coord_type req_box_max_y,
   input  wire rbs_pkg::coord_type req_box_max_z,
   input  wire rbs_pkg::coord_type req_ray_origin_x,
   input  wire rbs_pkg::coord_type req_ray_origin_y,
   input  wire rbs_pkg::coord_type req_ray_origin_z,
   input  wire rbs_pkg::coord_type req_ray_dir_x,
   input  wire rbs_pkg::coord_type req_ray_dir_y,
   input  wire rbs_pkg::coord_type req_ray_dir_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit
);
   import rbs_pkg::*;

   logic                advance;
   logic                accept;
   logic [LANE_LAT-1:0] vld_ff, vld_in;
   logic                rsp_valid_ff, rsp_hit_ff;
   logic                hit;

   coord_type bmin [0:NUM_AXES-1];
   coord_type bmax [0:NUM_AXES-1];
   coord_type orig [0:NUM_AXES-1];
   coord_type dirv [0:NUM_AXES-1];
   coord_type t_min [0:NUM_AXES-1];
   coord_type t_max [0:NUM_AXES-1];

   assign bmin = '{req_box_min_x, req_box_min_y, req_box_min_z};
   assign bmax = '{req_box_max_x, req_box_max_y, req_box_max_z};
   assign orig = '{req_ray_origin_x, req_ray_origin_y, req_ray_origin_z};
   assign dirv = '{req_ray_dir_x, req_ray_dir_y, req_ray_dir_z};

   // pipeline moves whenever the output word is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      rbs_div_lane u_lane_min (
         .clock (clock), .en (advance),
         .corner(bmin[a]), .origin(orig[a]), .dir(dirv[a]), .dist_out(t_min[a])
      );
      rbs_div_lane u_lane_max (
         .clock (clock), .en (advance),
         .corner(bmax[a]), .origin(orig[a]), .dir(dirv[a]), .dist_out(t_max[a])
      );
   end

   rbs_merge u_merge (.t_min(t_min), .t_max(t_max), .hit(hit));

   assign vld_in = {vld_ff[LANE_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_hit_ff <= hit;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   `RBS_ASSERT_NEXT(a_accept_enters, clock, reset, accept, vld_ff[0])
   `RBS_ASSERT_NEXT(a_tail_to_out, clock, reset, advance && vld_ff[LANE_LAT-1], rsp_valid_ff)
   `RBS_ASSERT_NEXT(a_hold_on_stall, clock, reset, !advance, $stable(vld_ff))
   `RBS_ASSERT(a_reset_clears, clock, 1'b0, $past(reset), !rsp_valid_ff && vld_ff == '0)
endmodule
`default_nettype wire

// File: rtl/core/rbs_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_div_lane: plane distance lane
// (corner - origin) / dir in Q format, restoring divide one bit per stage,
// saturated to the coordinate range.
// ----------------------------------------------------------------------------
module rbs_div_lane (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire rbs_pkg::coord_type corner,
   input  wire rbs_pkg::coord_type origin,
   input  wire rbs_pkg::coord_type dir,
   output rbs_pkg::coord_type      dist_out
);
   import rbs_pkg::*;

   logic signed [NUM_W-1:0] diff;
   logic                    num_neg;
   logic [NUM_W-1:0]        num_mag;
   logic                    den_neg;
   logic [COORD_WIDTH-1:0]  den_mag;

   logic [REM_W-1:0]       rem_ff [0:DIVD_W];
   logic [DIVD_W-1:0]      dvd_ff [0:DIVD_W];
   logic [DIVD_W-1:0]      q_ff   [0:DIVD_W];
   logic [COORD_WIDTH-1:0] den_ff [0:DIVD_W];
   logic                   neg_ff [0:DIVD_W];
   logic                   dz_ff  [0:DIVD_W];
   logic                   nz_ff  [0:DIVD_W];

   coord_type dist_ff, dist_in;

   always_comb begin
      diff    = {corner[COORD_WIDTH-1], corner} - {origin[COORD_WIDTH-1], origin};
      num_neg = diff[NUM_W-1];
      num_mag = num_neg ? NUM_W'(-diff) : NUM_W'(diff);
      den_neg = dir[COORD_WIDTH-1];
      den_mag = den_neg ? COORD_WIDTH'(-dir) : COORD_WIDTH'(dir);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         dvd_ff[0] <= {num_mag, {FRAC_BITS{1'b0}}};
         q_ff[0]   <= '0;
         den_ff[0] <= den_mag;
         neg_ff[0] <= (den_mag == '0) ? num_neg : (num_neg ^ den_neg);
         dz_ff[0]  <= (den_mag == '0);
         nz_ff[0]  <= (num_mag == '0);
      end
   end

   for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
      logic [REM_W-1:0] rem_sh;
      logic             ge;
      always_comb begin
         rem_sh = {rem_ff[k][REM_W-2:0], dvd_ff[k][DIVD_W-1]};
         ge     = rem_sh >= {1'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? (rem_sh - {1'b0, den_ff[k]}) : rem_sh;
            dvd_ff[k+1] <= {dvd_ff[k][DIVD_W-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][DIVD_W-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            dz_ff[k+1]  <= dz_ff[k];
            nz_ff[k+1]  <= nz_ff[k];
         end
      end
   end

   always_comb begin
      if (dz_ff[DIVD_W]) begin
         if (nz_ff[DIVD_W])       dist_in = '0;
         else if (neg_ff[DIVD_W]) dist_in = COORD_MIN;
         else                     dist_in = COORD_MAX;
      end else if (neg_ff[DIVD_W]) begin
         dist_in = (q_ff[DIVD_W] > Q_NEG_LIM) ? COORD_MIN
                 : coord_type'(-q_ff[DIVD_W][COORD_WIDTH-1:0]);
      end else begin
         dist_in = (q_ff[DIVD_W] > Q_POS_LIM) ? COORD_MAX
                 : coord_type'(q_ff[DIVD_W][COORD_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) dist_ff <= dist_in;
   end

   assign dist_out = dist_ff;
endmodule
`default_nettype wire

// File: rtl/core/rbs_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_merge: slab interval merge
// Narrows entry/exit over the three axes and decides the hit.
// ----------------------------------------------------------------------------
module rbs_merge (
   input  wire rbs_pkg::coord_type t_min [0:rbs_pkg::NUM_AXES-1],
   input  wire rbs_pkg::coord_type t_max [0:rbs_pkg::NUM_AXES-1],
   output logic                    hit
);
   import rbs_pkg::*;

   coord_type lo [0:NUM_AXES-1];
   coord_type hi [0:NUM_AXES-1];
   coord_type entry, exit_d;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         lo[a] = (t_min[a] < t_max[a]) ? t_min[a] : t_max[a];
         hi[a] = (t_min[a] < t_max[a]) ? t_max[a] : t_min[a];
      end
      entry  = lo[0];
      exit_d = hi[0];
      for (int a = 1; a < NUM_AXES; a++) begin
         if (lo[a] > entry)  entry  = lo[a];
         if (hi[a] < exit_d) exit_d = hi[a];
      end
      if (entry < 0) entry = '0;
      hit = exit_d > entry;
   end
endmodule
`default_nettype wire

// File: test/ray_box_slab_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_tb: self-checking bench for the ray/box slab test
// Directed corner rows, then random rays and boxes with random gaps on both
// channels; every hit word is checked in order against a local slab model.
// ----------------------------------------------------------------------------
module ray_box_slab_test_tb;
   import rbs_pkg::*;

   localparam int NUM_RANDOM = 800;
   localparam int WATCHDOG   = 5000;
   localparam int DRAIN      = 80;

   typedef struct {
      coord_type bmin [3];
      coord_type bmax [3];
      coord_type org  [3];
      coord_type dir  [3];
   } ray_box_type;

   // hit column of the directed table: known value, or left to the model
   typedef enum logic [1:0] {HIT_NO, HIT_YES, HIT_MODEL} hit_pick_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   coord_type req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   coord_type req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   coord_type req_ray_origin_x = '0, req_ray_origin_y = '0, req_ray_origin_z = '0;
   coord_type req_ray_dir_x = '0, req_ray_dir_y = '0, req_ray_dir_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic rsp_hit;

   bit hit_queue [$];
   int errors = 0;
   int words_in = 0, words_out = 0, hits_seen = 0;
   int idle_cycles = 0;
   bit stim_done = 0;
   bit long_hold = 0;

   ray_box_slab_test uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   // plane distance: (corner - origin) * 2^FRAC / dir, truncated, saturated
   function automatic logic signed [63:0] plane_dist(coord_type corner, coord_type origin,
                                                      coord_type dir);
      logic signed [127:0] num, den, quo;
      num = (128'(signed'(corner)) - 128'(signed'(origin))) <<< FRAC_BITS;
      den = 128'(signed'(dir));
      if (den == 0) begin
         if (num == 0) return 0;
         return num < 0 ? 64'(signed'(COORD_MIN)) : 64'(signed'(COORD_MAX));
      end
      quo = num / den;
      if (quo > 128'(signed'(COORD_MAX))) return 64'(signed'(COORD_MAX));
      if (quo < 128'(signed'(COORD_MIN))) return 64'(signed'(COORD_MIN));
      return 64'(quo);
   endfunction

   function automatic bit slab_hit(ray_box_type rb);
      logic signed [63:0] t1, t2, lo, hi, t_in, t_out;
      for (int a = 0; a < 3; a++) begin
         t1 = plane_dist(rb.bmin[a], rb.org[a], rb.dir[a]);
         t2 = plane_dist(rb.bmax[a], rb.org[a], rb.dir[a]);
         lo = t1 < t2 ? t1 : t2;
         hi = t1 < t2 ? t2 : t1;
         if (a == 0 || lo > t_in) t_in = lo;
         if (a == 0 || hi < t_out) t_out = hi;
      end
      if (t_in < 0) t_in = 0;
      return t_out > t_in;
   endfunction

   // ------------------------------------------------------------- stimulus
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3: return coord_type'($urandom);
         default: return coord_type'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
      endcase
   endfunction

   function automatic ray_box_type rand_ray_box();
      ray_box_type rb;
      coord_type c0, c1;
      for (int a = 0; a < 3; a++) begin
         c0 = rand_coord();
         c1 = rand_coord();
         // mostly well-ordered boxes, some swapped corners
         if ($urandom_range(0, 7) != 0 && c0 > c1) begin
            rb.bmin[a] = c1; rb.bmax[a] = c0;
         end else begin
            rb.bmin[a] = c0; rb.bmax[a] = c1;
         end
         rb.org[a] = rand_coord();
         case ($urandom_range(0, 7))
            0: rb.dir[a] = '0;
            1: rb.dir[a] = coord_type'($urandom);
            2: rb.dir[a] = coord_type'(int'($urandom_range(0, 16)) - 8);
            default: rb.dir[a] = coord_type'(int'($urandom_range(0, 4 << 16)) - (2 << 16));
         endcase
      end
      return rb;
   endfunction

   function automatic ray_box_type make_rb(coord_type mn, coord_type mx, coord_type o,
                                           coord_type d);
      ray_box_type rb;
      for (int a = 0; a < 3; a++) begin
         rb.bmin[a] = mn; rb.bmax[a] = mx; rb.org[a] = o; rb.dir[a] = d;
      end
      return rb;
   endfunction

   task automatic send_word(ray_box_type rb, hit_pick_type pick);
      bit want;
      want = slab_hit(rb);
      if (pick != HIT_MODEL && want != (pick == HIT_YES)) begin
         $display("%0t: table row disagrees with model: expected %0d actual %0d",
                  $time, pick == HIT_YES, want);
         errors++;
      end
      {req_box_min_x, req_box_min_y, req_box_min_z} = {rb.bmin[0], rb.bmin[1], rb.bmin[2]};
      {req_box_max_x, req_box_max_y, req_box_max_z} = {rb.bmax[0], rb.bmax[1], rb.bmax[2]};
      {req_ray_origin_x, req_ray_origin_y, req_ray_origin_z} = {rb.org[0], rb.org[1], rb.org[2]};
      {req_ray_dir_x, req_ray_dir_y, req_ray_dir_z} = {rb.dir[0], rb.dir[1], rb.dir[2]};
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      hit_queue.push_back(want);
      words_in++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic random_gap();
      int n;
      n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                                    : $urandom_range(1, 3));
      repeat (n) @(negedge clock);
   endtask

   localparam int N_DIRECTED = 12;
   ray_box_type  dir_rows [N_DIRECTED];
   hit_pick_type dir_pick [N_DIRECTED];
   localparam coord_type ONE = 32'sh0001_0000;

   initial begin
      ray_box_type rb;
      // unit box, ray from -2 toward +x/y/z: hit
      dir_rows[0] = make_rb(-ONE, ONE, -2 * ONE, ONE);            dir_pick[0] = HIT_YES;
      // pointing away: miss
      dir_rows[1] = make_rb(-ONE, ONE, -2 * ONE, -ONE);           dir_pick[1] = HIT_NO;
      // origin inside, zero direction on all axes: entry min, exit max
      dir_rows[2] = make_rb(-ONE, ONE, '0, '0);                   dir_pick[2] = HIT_YES;
      // origin outside, zero direction: miss
      dir_rows[3] = make_rb(ONE, 2 * ONE, '0, '0);                dir_pick[3] = HIT_NO;
      // origin on a face, zero direction gives distance 0
      dir_rows[4] = make_rb('0, ONE, '0, '0);                     dir_pick[4] = HIT_MODEL;
      // full-range box, tiny direction (saturated quotients) and full-scale direction
      dir_rows[5] = make_rb(COORD_MIN, COORD_MAX, '0, 32'sd1);    dir_pick[5] = HIT_MODEL;
      dir_rows[6] = make_rb(COORD_MIN, COORD_MAX, COORD_MAX, 32'sd1); dir_pick[6] = HIT_MODEL;
      dir_rows[7] = make_rb(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN); dir_pick[7] = HIT_MODEL;
      // swapped corners
      dir_rows[8] = make_rb(ONE, -ONE, -2 * ONE, ONE);            dir_pick[8] = HIT_MODEL;
      // degenerate box
      dir_rows[9] = make_rb(ONE, ONE, '0, ONE);                   dir_pick[9] = HIT_NO;
      dir_rows[10] = make_rb(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX); dir_pick[10] = HIT_MODEL;
      dir_rows[11] = make_rb('1, '1, '1, '1);                     dir_pick[11] = HIT_MODEL;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (dir_rows[i]) send_word(dir_rows[i], dir_pick[i]);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         // one long receiver hold-off partway through, sender keeps offering
         if (i == 300) long_hold = 1;
         rb = rand_ray_box();
         send_word(rb, HIT_MODEL);
         if (!long_hold) random_gap();
      end
      stim_done = 1;
   end

   // ------------------------------------------------------------- receiver
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall = 1;
            repeat (200) @(negedge clock);
            long_hold = 0;
         end
         rsp_stall = 0;
         n = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(1, 30);
         repeat (n) @(negedge clock);
         if (!long_hold && $urandom_range(0, 2) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
               @(negedge clock);
         end
      end
   end

   // --------------------------------------------------------------- checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         hits_seen += rsp_hit;
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected word: expected none actual hit=%0d", $time, rsp_hit);
            errors++;
         end else begin
            bit want;
            want = hit_queue.pop_front();
            if (rsp_hit !== want) begin
               $display("%0t: hit mismatch: expected %0d actual %0d", $time, want, rsp_hit);
               errors++;
            end
         end
      end
   end

   // -------------------------------------------------------- watchdog / end
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      fork
         begin
            wait (stim_done && hit_queue.size() == 0);
            repeat (DRAIN) @(posedge clock);
         end
         begin
            wait (idle_cycles >= WATCHDOG);
            $display("%0t: watchdog expired, %0d words outstanding", $time, hit_queue.size());
            errors++;
         end
      join_any
      if (hit_queue.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, hit_queue.size());
         errors++;
      end
      $display("Sent %0d ray/box words (%0d directed), checked %0d results, %0d hits.",
               words_in, N_DIRECTED, words_out, hits_seen);
      $display("Covered saturation, zero directions, swapped corners and long output stalls.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
